// File: rtl/hpp_pkg.sv
`default_nettype none

package hpp_pkg;

  // command codes on the action field
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_PLAY = 2'd1;
  localparam logic [1:0] ACT_STOP = 2'd2;
  localparam logic [1:0] ACT_RSVD = 2'd3;

  // pattern codes
  localparam logic [2:0] PAT_NONE     = 3'd0;
  localparam logic [2:0] PAT_SHORT    = 3'd1;
  localparam logic [2:0] PAT_LONG     = 3'd2;
  localparam logic [2:0] PAT_DOUBLE   = 3'd3;
  localparam logic [2:0] PAT_FAULT    = 3'd4;
  localparam logic [2:0] PAT_LINKED   = 3'd5;
  localparam logic [2:0] PAT_SPARE_LO = 3'd6;
  localparam logic [2:0] PAT_SPARE_HI = 3'd7;

  localparam logic [7:0] ELAPSED_MAX = 8'd255;

  // number of steps in a pattern, zero for unknown codes
  function automatic logic [2:0] pat_steps(input logic [2:0] code);
    logic [2:0] n;
    unique case (code)
      PAT_SHORT:  n = 3'd1;
      PAT_LONG:   n = 3'd1;
      PAT_DOUBLE: n = 3'd3;
      PAT_FAULT:  n = 3'd3;
      PAT_LINKED: n = 3'd5;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

  // step duration in milliseconds
  function automatic logic [7:0] pat_dur(input logic [2:0] code, input logic [2:0] step);
    logic [7:0] d;
    d = 8'd0;
    unique case (code)
      PAT_SHORT:     if (step == 3'd0) d = 8'd80;
      PAT_LONG:      if (step == 3'd0) d = 8'd150;
      PAT_DOUBLE:    if (step <= 3'd2) d = 8'd50;
      PAT_FAULT: begin
        if (step == 3'd0 || step == 3'd2) d = 8'd200;
        else if (step == 3'd1) d = 8'd100;
      end
      PAT_LINKED: begin
        if (step == 3'd0 || step == 3'd2 || step == 3'd4) d = 8'd50;
        else if (step == 3'd1 || step == 3'd3) d = 8'd60;
      end
      default:       d = 8'd0;
    endcase
    return d;
  endfunction

  // motor level of a step: every pattern alternates on, off, on...
  function automatic logic pat_lvl(input logic [2:0] code, input logic [2:0] step);
    return (pat_steps(code) != 3'd0) && (step < pat_steps(code)) && !step[0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/hpp_cmd_if.sv
`default_nettype none

interface hpp_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [2:0] pattern_code;

  modport source (output valid, output action, output pattern_code, input ready);
  modport sink   (input valid, input action, input pattern_code, output ready);
endinterface

`default_nettype wire

// File: rtl/hpp_res_if.sv
`default_nettype none

interface hpp_res_if;
  logic valid;
  logic ready;
  logic motor_drive;
  logic busy_res;

  modport source (output valid, output motor_drive, output busy_res, input ready);
  modport sink   (input valid, input motor_drive, input busy_res, output ready);
endinterface

`default_nettype wire

// File: rtl/haptic_pattern_player_core.sv
// haptic pattern player: drives a vibration motor through fixed on/off patterns
// cmd channel: tick (one per millisecond), play (with pattern code) or stop
// res channel: one item for every cmd item, giving motor level and busy flag
//   as they stand after that cmd item has been applied
// res valid is registered: an accepted item passes the cmd register and then
//   the res register, and a stalled res holds it in the cmd register
// throughput: one item per cycle while res is not stalled; the state update is a
//   single compare and increment on the elapsed counter between the cmd register and res register
// a two-deep arrangement (cmd register, res register) lets a new item be taken
//   while the previous result waits on the receiver
// when res.ready is held low, the cmd register fills and cmd.ready drops
//   one item later; nothing is lost or repeated
// synchronous reset clears the pattern state (motor off, idle) and empties
//   both registers
`default_nettype none

module haptic_pattern_player_core (
  input  wire logic       clk,
  input  wire logic       rst,
  hpp_cmd_if.sink         cmd,
  hpp_res_if.source       res
);

  // cmd register
  logic       cmd_valid;
  logic [1:0] cmd_action;
  logic [2:0] cmd_code;

  // pattern state
  logic       playing, playing_next;
  logic [2:0] current_pattern, current_pattern_next;
  logic [2:0] step_index, step_index_next;
  logic [7:0] elapsed_ms, elapsed_ms_next;
  logic       motor_level, motor_level_next;

  // res register
  logic res_valid;
  logic res_motor;
  logic res_busy;

  logic advance;
  logic cmd_take;

  assign advance  = cmd_valid && (!res_valid || res.ready);
  assign cmd.ready = !cmd_valid || advance;
  assign cmd_take = cmd.valid && cmd.ready;

  // next pattern state for the item in the cmd register
  logic [7:0] el_inc;
  logic [2:0] nxt_step;
  logic [2:0] cur_steps;

  always_comb begin
    cur_steps = hpp_pkg::pat_steps(current_pattern);
    el_inc    = (elapsed_ms < hpp_pkg::ELAPSED_MAX) ? elapsed_ms + 8'd1 : elapsed_ms;
    nxt_step  = step_index + 3'd1;

    playing_next         = playing;
    current_pattern_next = current_pattern;
    step_index_next      = step_index;
    elapsed_ms_next      = elapsed_ms;
    motor_level_next     = motor_level;

    unique case (cmd_action)
      hpp_pkg::ACT_PLAY: begin
        current_pattern_next = cmd_code;
        step_index_next      = 3'd0;
        elapsed_ms_next      = 8'd0;
        if (hpp_pkg::pat_steps(cmd_code) != 3'd0) begin
          playing_next     = 1'b1;
          motor_level_next = hpp_pkg::pat_lvl(cmd_code, 3'd0);
        end else begin
          // unknown code: idle, motor level left as it was
          playing_next = 1'b0;
        end
      end
      hpp_pkg::ACT_STOP: begin
        motor_level_next     = 1'b0;
        playing_next         = 1'b0;
        current_pattern_next = hpp_pkg::PAT_NONE;
      end
      hpp_pkg::ACT_TICK: begin
        if (playing) begin
          if (step_index >= cur_steps) begin
            // no valid step left, behaves as stop
            motor_level_next     = 1'b0;
            playing_next         = 1'b0;
            current_pattern_next = hpp_pkg::PAT_NONE;
          end else begin
            elapsed_ms_next = el_inc;
            if (el_inc >= hpp_pkg::pat_dur(current_pattern, step_index)) begin
              step_index_next = nxt_step;
              if (nxt_step >= cur_steps) begin
                // end of the list
                motor_level_next     = 1'b0;
                playing_next         = 1'b0;
                current_pattern_next = hpp_pkg::PAT_NONE;
              end else begin
                elapsed_ms_next  = 8'd0;
                motor_level_next = hpp_pkg::pat_lvl(current_pattern, nxt_step);
              end
            end
          end
        end
      end
      default: ;  // unused action code, no change
    endcase
  end

  // cmd register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (cmd.ready) begin
      cmd_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cmd_action <= cmd.action;
      cmd_code   <= cmd.pattern_code;
    end
  end

  // pattern state, updated as each item leaves the cmd register
  always_ff @(posedge clk) begin
    if (rst) begin
      playing         <= 1'b0;
      current_pattern <= hpp_pkg::PAT_NONE;
      step_index      <= 3'd0;
      elapsed_ms      <= 8'd0;
      motor_level     <= 1'b0;
    end else if (advance) begin
      playing         <= playing_next;
      current_pattern <= current_pattern_next;
      step_index      <= step_index_next;
      elapsed_ms      <= elapsed_ms_next;
      motor_level     <= motor_level_next;
    end
  end

  // res register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_motor <= motor_level_next;
      res_busy  <= playing_next;
    end
  end

  assign res.valid       = res_valid;
  assign res.motor_drive = res_motor;
  assign res.busy_res    = res_busy;

endmodule

`default_nettype wire

// File: rtl/hpp_checker.sv
`default_nettype none

module hpp_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic cmd_valid,
  input wire logic cmd_ready,
  input wire logic res_valid,
  input wire logic res_ready,
  input wire logic res_motor_drive,
  input wire logic res_busy_res
);

  // reset empties the result side
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_motor_drive) && $stable(res_busy_res))
    else $error("stalled result changed");

  // cmd side only backs up behind a stalled result
  assert property (@(posedge clk) disable iff (rst)
    !cmd_ready |-> res_valid && !res_ready)
    else $error("cmd not ready without a stalled result");

  // a fresh result follows an item accepted earlier through the cmd register
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(cmd_valid && cmd_ready, 2))
    else $error("result without an accepted item");

endmodule

bind haptic_pattern_player_core hpp_checker u_hpp_checker (
  .clk             (clk),
  .rst             (rst),
  .cmd_valid       (cmd.valid),
  .cmd_ready       (cmd.ready),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .res_motor_drive (res.motor_drive),
  .res_busy_res    (res.busy_res)
);

`default_nettype wire
